>>> sv/sse_pkg.sv
package sse_pkg;

    localparam int KEY_W     = 32;
    localparam int ACTION_W  = 2;
    localparam int ENTRY_W   = 7;
    localparam int ENTRY_MAX = 127;
    localparam int GROUP_W   = 32;

    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic cmp_en;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

>>> sv/sorted_set_engine.sv
// sorted set engine: holds up to CAPACITY distinct signed 32-bit keys in
// ascending order, one key per cell of a row of compare cells.
// request channel: drive i_action (0 query, 1 insert, 2 delete) and
// i_value with start high; the beat is taken at an edge where busy is low.
// busy stays high while the request is being worked on.
// result channel: o_valid is high for exactly one cycle with o_success,
// o_full_error and o_entry_count; the receiver cannot stall it, and the
// result must be taken in that cycle.
// steps: a request passes the steps below in order, and its result is
// taken at the same edge at which a new request can first be taken, so a
// new request is not taken before the last is through. the steps are: every cell compares
// its key, a registered first level of the match or-tree, then all cells
// shift in one step while the result register is loaded.
// action code 3 is a no-op that reports the current count.
// o_entry_count saturates at 127 for capacities above 127.
// reset: synchronous, active low; the store is empty afterward and no
// clearing pass is needed since cells past the count are never read.
module sorted_set_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sse_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [sse_pkg::KEY_W-1:0]    i_value,
    output logic                                o_valid,
    output logic                                o_success,
    output logic                                o_full_error,
    output logic [sse_pkg::ENTRY_W-1:0]         o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    sse_pkg::t_state                   r_state, n_state;
    logic [sse_pkg::ACTION_W-1:0]      r_action;
    logic signed [sse_pkg::KEY_W-1:0]  r_value;
    logic [CW-1:0]                     r_count, n_count;
    logic                              r_valid, n_valid;
    logic                              r_success, n_success;
    logic                              r_full, n_full;
    logic [sse_pkg::ENTRY_W-1:0]       r_shown, n_shown;
    sse_pkg::t_cell_ctl                w_ctl;
    logic                              w_found;
    logic                              w_full_now;
    logic [31:0]                       w_cnt32;

    logic signed [sse_pkg::KEY_W-1:0]  w_key [CAPACITY];
    logic [CAPACITY-1:0]               w_lt;
    logic [CAPACITY-1:0]               w_eq;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                             w_prev_lt;
            logic signed [sse_pkg::KEY_W-1:0] w_prev_key;
            logic signed [sse_pkg::KEY_W-1:0] w_next_key;
            logic                             w_live;

            if (gi == 0) begin : g_first
                assign w_prev_lt  = 1'b1;
                assign w_prev_key = r_value;
            end else begin : g_mid
                assign w_prev_lt  = w_lt[gi-1];
                assign w_prev_key = w_key[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next_key = '0;
            end else begin : g_body
                assign w_next_key = w_key[gi+1];
            end
            assign w_live = (CW'(gi) < r_count);

            sse_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_value    (r_value),
                .i_live     (w_live),
                .i_prev_lt  (w_prev_lt),
                .i_prev_key (w_prev_key),
                .i_next_key (w_next_key),
                .o_key      (w_key[gi]),
                .o_lt       (w_lt[gi]),
                .o_eq       (w_eq[gi])
            );
        end
    endgenerate

    sse_found #(.CAPACITY(CAPACITY)) u_found (
        .i_clk   (i_clk),
        .i_eq    (w_eq),
        .o_found (w_found)
    );

    assign w_full_now = (r_count == CW'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sse_pkg::ST_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_success <= 1'b0;
            r_full    <= 1'b0;
            r_shown   <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_success <= n_success;
            r_full    <= n_full;
            r_shown   <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sse_pkg::ST_IDLE && start) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_success  = r_success;
        n_full     = r_full;
        n_shown    = r_shown;
        w_ctl      = '0;
        w_cnt32    = 32'(r_count);
        unique case (r_state)
            sse_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = sse_pkg::ST_CMP;
                end
            end
            sse_pkg::ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_state      = sse_pkg::ST_GRP;
            end
            sse_pkg::ST_GRP: begin
                n_state = sse_pkg::ST_APPLY;
            end
            sse_pkg::ST_APPLY: begin
                n_state   = sse_pkg::ST_IDLE;
                n_valid   = 1'b1;
                n_success = 1'b0;
                n_full    = 1'b0;
                priority if (r_action == sse_pkg::ACT_QUERY) begin
                    n_success = w_found;
                end else if (r_action == sse_pkg::ACT_INSERT) begin
                    if (!w_found) begin
                        if (w_full_now) begin
                            n_full = 1'b1;
                        end else begin
                            w_ctl.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_success = 1'b1;
                        end
                    end
                end else if (r_action == sse_pkg::ACT_DELETE) begin
                    if (w_found) begin
                        w_ctl.del = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_success = 1'b1;
                    end
                end else begin
                    n_success = 1'b0;
                end
                w_cnt32 = 32'(n_count);
                n_shown = (w_cnt32 > 32'(sse_pkg::ENTRY_MAX)) ?
                          sse_pkg::ENTRY_W'(sse_pkg::ENTRY_MAX) :
                          w_cnt32[sse_pkg::ENTRY_W-1:0];
            end
            default: begin
                n_state = sse_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != sse_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_success     = r_success;
    assign o_full_error  = r_full;
    assign o_entry_count = r_shown;

endmodule

>>> sv/sse_cell.sv
module sse_cell (
    input  logic                              i_clk,
    input  sse_pkg::t_cell_ctl                i_ctl,
    input  logic signed [sse_pkg::KEY_W-1:0]  i_value,
    input  logic                              i_live,
    input  logic                              i_prev_lt,
    input  logic signed [sse_pkg::KEY_W-1:0]  i_prev_key,
    input  logic signed [sse_pkg::KEY_W-1:0]  i_next_key,
    output logic signed [sse_pkg::KEY_W-1:0]  o_key,
    output logic                              o_lt,
    output logic                              o_eq
);

    logic signed [sse_pkg::KEY_W-1:0] r_key;
    logic                             r_lt;
    logic                             r_eq;

    // compare against the request, registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= i_live && (r_key < i_value);
            r_eq <= i_live && (r_key == i_value);
        end
    end

    // shift right on insert, left on delete, at and above the slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_prev_lt ? i_value : i_prev_key;
        end else if (i_ctl.del && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

>>> sv/sse_found.sv
module sse_found #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic [CAPACITY-1:0] i_eq,
    output logic                o_found
);

    localparam int NGRP  = (CAPACITY + sse_pkg::GROUP_W - 1) / sse_pkg::GROUP_W;
    localparam int PAD_W = NGRP * sse_pkg::GROUP_W;

    logic [PAD_W-1:0] w_pad;
    logic [NGRP-1:0]  r_grp;

    assign w_pad = PAD_W'(i_eq);

    // first level of the or tree, registered
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= |w_pad[g*sse_pkg::GROUP_W +: sse_pkg::GROUP_W];
        end
    end

    assign o_found = |r_grp;

endmodule

>>> sv/sse_checker.sv
module sse_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_valid,
    input  logic                                o_success,
    input  logic                                o_full_error,
    input  logic [sse_pkg::ENTRY_W-1:0]         o_entry_count
);

    localparam int SHOWN_FULL = (CAPACITY > sse_pkg::ENTRY_MAX) ?
                                sse_pkg::ENTRY_MAX : CAPACITY;

    // a taken beat makes the block busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request beat taken but busy stayed low");

    // result strobe lasts one cycle
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // result shows only when the block is ready again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // a refused insert reports a full store and no success
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_error) |->
            (!o_success && o_entry_count == sse_pkg::ENTRY_W'(SHOWN_FULL)))
        else $error("full error with wrong count or success");

endmodule

bind sorted_set_engine sse_checker #(.CAPACITY(CAPACITY)) u_sse_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY = 64;
    localparam int POOL_N   = 96;
    localparam int RAND_N   = 1300;
    localparam int CALM_N   = 200;
    localparam int SEG_N    = 100;
    localparam logic [sse_pkg::ACTION_W-1:0] ACT_NOP = 2'd3;
    localparam logic signed [sse_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [sse_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef logic signed [sse_pkg::KEY_W-1:0] t_key;

    typedef struct packed {
        logic                        success;
        logic                        full_error;
        logic [sse_pkg::ENTRY_W-1:0] entry_count;
    } t_outcome;

    class key_set_board;
        t_key     held_keys[$];
        t_outcome due_outcomes[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return due_outcomes.size();
        endfunction

        function int held();
            return held_keys.size();
        endfunction

        // apply one request to the shadow set and queue the result it must give
        function void note_request(logic [sse_pkg::ACTION_W-1:0] act, t_key val);
            int       pos;
            bit       hit;
            int       cnt;
            t_outcome res;
            pos = 0;
            while (pos < held_keys.size() && held_keys[pos] < val)
                pos++;
            hit = (pos < held_keys.size()) && (held_keys[pos] == val);
            res = '0;
            case (act)
                sse_pkg::ACT_QUERY: begin
                    res.success = hit;
                end
                sse_pkg::ACT_INSERT: begin
                    if (!hit) begin
                        if (held_keys.size() >= CAPACITY) begin
                            res.full_error = 1'b1;
                        end else begin
                            held_keys.insert(pos, val);
                            res.success = 1'b1;
                        end
                    end
                end
                sse_pkg::ACT_DELETE: begin
                    if (hit) begin
                        held_keys.delete(pos);
                        res.success = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            cnt = held_keys.size();
            res.entry_count = (cnt > sse_pkg::ENTRY_MAX) ?
                              sse_pkg::ENTRY_MAX[sse_pkg::ENTRY_W-1:0] :
                              cnt[sse_pkg::ENTRY_W-1:0];
            due_outcomes.push_back(res);
        endfunction

        task check_result(logic success, logic full_error,
                          logic [sse_pkg::ENTRY_W-1:0] entry_count);
            t_outcome want;
            if (due_outcomes.size() == 0) begin
                report($sformatf("result with nothing pending: success %0b full %0b count %0d",
                                 success, full_error, entry_count));
            end else begin
                want = due_outcomes.pop_front();
                if (success !== want.success)
                    report($sformatf("success %0b, want %0b", success, want.success));
                if (full_error !== want.full_error)
                    report($sformatf("full_error %0b, want %0b", full_error, want.full_error));
                if (entry_count !== want.entry_count)
                    report($sformatf("entry_count %0d, want %0d",
                                     entry_count, want.entry_count));
            end
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [sse_pkg::ACTION_W-1:0]  i_action = sse_pkg::ACT_QUERY;
    t_key                          i_value = '0;
    logic                          o_valid;
    logic                          o_success;
    logic                          o_full_error;
    logic [sse_pkg::ENTRY_W-1:0]   o_entry_count;

    key_set_board sb = new();
    t_key         key_pool[POOL_N];

    sorted_set_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_success(o_success),
        .o_full_error(o_full_error),
        .o_entry_count(o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // results first so a result and a new beat on one edge stay in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_success, o_full_error, o_entry_count);
            if (start && !busy)
                sb.note_request(i_action, i_value);
        end
    end

    task automatic send_request(input logic [sse_pkg::ACTION_W-1:0] act, input t_key val);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_requests(input int cycles);
        start    <= 1'b0;
        i_action <= sse_pkg::ACTION_W'($urandom);
        i_value  <= t_key'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic t_key pick_key();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(POOL_N - 1)];
        return t_key'($urandom);
    endfunction

    initial begin
        int ins_w;
        int del_w;
        int idle_pct;
        int roll;
        logic [sse_pkg::ACTION_W-1:0] act;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < POOL_N; i++)
            key_pool[i] = t_key'($urandom);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(sse_pkg::ACT_QUERY, '0);
        send_request(sse_pkg::ACT_DELETE, 5);
        send_request(sse_pkg::ACT_INSERT, KEY_MIN);
        send_request(sse_pkg::ACT_INSERT, KEY_MAX);
        send_request(sse_pkg::ACT_INSERT, '0);
        send_request(sse_pkg::ACT_INSERT, -1);
        send_request(sse_pkg::ACT_INSERT, 1);
        send_request(sse_pkg::ACT_INSERT, '0);
        send_request(sse_pkg::ACT_QUERY, KEY_MIN);
        send_request(sse_pkg::ACT_QUERY, KEY_MAX);
        send_request(sse_pkg::ACT_QUERY, 2);
        send_request(ACT_NOP, -1);
        send_request(sse_pkg::ACT_DELETE, -1);
        send_request(sse_pkg::ACT_DELETE, -1);
        send_request(sse_pkg::ACT_QUERY, -1);
        send_request(sse_pkg::ACT_INSERT, 32'sh5555_5555);
        send_request(sse_pkg::ACT_INSERT, 32'shaaaa_aaaa);
        send_request(sse_pkg::ACT_QUERY, 32'sh5555_5555);
        send_request(sse_pkg::ACT_DELETE, KEY_MAX);
        send_request(sse_pkg::ACT_DELETE, KEY_MIN);
        send_request(ACT_NOP, KEY_MAX);
        send_request(sse_pkg::ACT_QUERY, 1);

        // segments alternate filling toward capacity, draining, and a mix
        for (int n = 0; n < RAND_N; n++) begin
            case ((n / SEG_N) % 3)
                0: begin ins_w = 85; del_w = 5; end
                1: begin ins_w = 15; del_w = 70; end
                default: begin ins_w = 40; del_w = 35; end
            endcase
            if (sb.held() >= CAPACITY && $urandom_range(1))
                ins_w = 90;
            idle_pct = ((n / SEG_N) % 2 == 1) ? 0 : 30;
            if (n >= RAND_N - CALM_N)
                idle_pct = 0;
            roll = $urandom_range(99);
            if (roll < 3)
                act = ACT_NOP;
            else if (roll < 3 + ins_w * 97 / 100)
                act = sse_pkg::ACT_INSERT;
            else if (roll < 3 + (ins_w + del_w) * 97 / 100)
                act = sse_pkg::ACT_DELETE;
            else
                act = sse_pkg::ACT_QUERY;
            if ($urandom_range(99) < idle_pct)
                pause_requests($urandom_range(1, 6));
            send_request(act, pick_key());
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #400000;
        $display("tb failed");
        $finish;
    end

endmodule
